// ----- rtl/core/aes_pkg.sv -----
// AES-128 package: S-box, GF(2^8) helpers and round functions.
package aes_pkg;

	localparam int NumRounds = 10;

	typedef logic [127:0] blk_t;

	localparam logic [1:0] CfgKeyHigh = 2'd0;
	localparam logic [1:0] CfgKeyLow  = 2'd1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i at bits [127-8i -: 8]
	function automatic logic [7:0] byte_at(input blk_t b, input int i);
		byte_at = b[127 - 8*i -: 8];
	endfunction

	function automatic blk_t next_key(input blk_t rk, input logic [7:0] rc);
		blk_t n;
		logic [31:0] t;
		t = {SBOX[byte_at(rk, 13)] ^ rc, SBOX[byte_at(rk, 14)],
			SBOX[byte_at(rk, 15)], SBOX[byte_at(rk, 12)]};
		n[127:96] = rk[127:96] ^ t;
		n[95:64]  = rk[95:64] ^ n[127:96];
		n[63:32]  = rk[63:32] ^ n[95:64];
		n[31:0]   = rk[31:0] ^ n[63:32];
		next_key = n;
	endfunction

	function automatic blk_t round_fn(input blk_t b, input blk_t rk, input logic last);
		blk_t s;
		blk_t m;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				s[127 - 8*(r + 4*c) -: 8] = SBOX[byte_at(b, r + 4*((c + r) % 4))];
			end
		end
		m = s;
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = byte_at(s, 4*c);
				a1 = byte_at(s, 4*c + 1);
				a2 = byte_at(s, 4*c + 2);
				a3 = byte_at(s, 4*c + 3);
				all = a0 ^ a1 ^ a2 ^ a3;
				m[127 - 32*c -: 8]      = a0 ^ all ^ xtime(a0 ^ a1);
				m[127 - 32*c - 8 -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
				m[127 - 32*c - 16 -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
				m[127 - 32*c - 24 -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		round_fn = m ^ rk;
	endfunction

endpackage

// ----- rtl/core/aes_round_stage.sv -----
// One AES round plus the matching key-schedule step, registered.
module aes_round_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           last,
	input  logic [7:0]     rc,
	input  logic           in_vld,
	input  aes_pkg::blk_t  in_blk,
	input  aes_pkg::blk_t  in_key,
	output logic           out_vld,
	output aes_pkg::blk_t  out_blk,
	output aes_pkg::blk_t  out_key
);
	import aes_pkg::*;

	blk_t nk;

	assign nk = next_key(in_key, rc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_key <= nk;
		out_blk <= round_fn(in_blk, nk, last);
	end
endmodule

// ----- rtl/core/aes128_block_encrypt_unit.sv -----
// AES-128 encryption top level: key registers and a ten-stage round pipeline.
//
// Encrypts one 128-bit block per clock under the key in key_high/key_low.
// An item is taken when start is high and busy is low; busy is always low, so a
// new block can enter every cycle. The ciphertext appears after the stage-0
// register for the initial key addition and one round stage per round, for one
// cycle with done high; the receiver cannot stall, and none is needed since the
// pipeline never holds. Each item carries its round keys along with it through
// the ten round stages. Key writes apply to items accepted afterwards; write
// the key only while no item is in flight.
module aes128_block_encrypt_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        done,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);
	import aes_pkg::*;

	logic [63:0] key_high_q, key_low_q;
	logic        vld_s [NumRounds+1];
	blk_t        blk_s [NumRounds+1];
	blk_t        key_s [NumRounds+1];
	logic [7:0]  rc_tab [NumRounds];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgKeyHigh[0:0]: key_high_q <= cfg_data;
				CfgKeyLow[0:0]:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 0: initial AddRoundKey
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		blk_s[0] <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
		key_s[0] <= {key_high_q, key_low_q};
	end

	// round constants: doubling chain fixed at elaboration
	always_comb begin
		rc_tab[0] = 8'h01;
		for (int i = 1; i < NumRounds; i++) begin
			rc_tab[i] = xtime(rc_tab[i-1]);
		end
	end

	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		aes_round_stage u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.last    (g == NumRounds - 1),
			.rc      (rc_tab[g]),
			.in_vld  (vld_s[g]),
			.in_blk  (blk_s[g]),
			.in_key  (key_s[g]),
			.out_vld (vld_s[g+1]),
			.out_blk (blk_s[g+1]),
			.out_key (key_s[g+1])
		);
	end

	assign done        = vld_s[NumRounds];
	assign cipher_high = blk_s[NumRounds][127:64];
	assign cipher_low  = blk_s[NumRounds][63:0];
endmodule

// ----- rtl/core/aes_checker.sv -----
// Port-level checks for the AES-128 encryption unit, bound to the top level.
module aes_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	localparam int Lat = 11;

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Lat done)
		else $error("item not delivered after fixed latency");

	a_nophantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Lat))
		else $error("result without matching item");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("pipeline refused an item");
endmodule

bind aes128_block_encrypt_unit aes_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);

// ----- dv/aes128_block_encrypt_unit_tb.sv -----
// Self-checking testbench for the AES-128 block encryption unit.
module aes128_block_encrypt_unit_tb;
	import aes_pkg::*;

	// S-box kept locally so the cipher prediction is independent of the RTL
	localparam logic [7:0] SUBST [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Byte-array view of a 128-bit block, byte 0 first
	typedef logic [7:0] state_t [16];

	// GF(2^8) doubling
	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Full AES-128 encryption of one block; key schedule done on the fly
	function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
		state_t s, rk, t;
		logic [7:0] rc, a0, a1, a2, a3, all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) begin
			s[i] = pt[127-8*i -: 8] ^ key[127-8*i -: 8];
			rk[i] = key[127-8*i -: 8];
		end
		rc = 8'h01;
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[r+4*c] = SUBST[s[r + 4*((c+r) % 4)]];
			s = t;
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					s[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
					s[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
					s[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
					s[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
				end
			end
			// round key: RotWord/SubWord of the last word plus round constant
			rk[0] = rk[0] ^ SUBST[rk[13]] ^ rc;
			rk[1] = rk[1] ^ SUBST[rk[14]];
			rk[2] = rk[2] ^ SUBST[rk[15]];
			rk[3] = rk[3] ^ SUBST[rk[12]];
			for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
			rc = gf_dbl(rc);
			for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
		return res;
	endfunction

	// Scoreboard: holds ciphertexts predicted for accepted blocks
	class cipher_board;
		logic [63:0] key_hi, key_lo;
		logic [127:0] pending[$];
		int errors;
		int checked;

		function void note_block(input logic [63:0] ph, input logic [63:0] pl);
			pending.push_back(aes_encrypt({key_hi, key_lo}, {ph, pl}));
		endfunction

		function void check_cipher(input logic [63:0] ch, input logic [63:0] cl);
			logic [127:0] exp_ct;
			if (pending.size() == 0) begin
				$display("%0t: unexpected ciphertext %h_%h", $time, ch, cl);
				errors++;
				return;
			end
			exp_ct = pending.pop_front();
			checked++;
			if (ch !== exp_ct[127:64]) begin
				$display("%0t: cipher_high expected %h actual %h", $time, exp_ct[127:64], ch);
				errors++;
			end
			if (cl !== exp_ct[63:0]) begin
				$display("%0t: cipher_low expected %h actual %h", $time, exp_ct[63:0], cl);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        start;
	logic        busy;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic        done;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	cipher_board board;
	int          blocks_sent;
	int          key_writes;
	int          burst_left;

	aes128_block_encrypt_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Results can't be stalled: sample every strobe at the edge
	always @(posedge clk) begin
		if (arst_n && done) board.check_cipher(cipher_high, cipher_low);
	end

	// Write one key half; only called while the pipeline is empty
	task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == CfgKeyHigh[0:0]) board.key_hi = val;
		else board.key_lo = val;
		key_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Present one block; start stays high across back-to-back items
	task automatic send_block(input logic [63:0] ph, input logic [63:0] pl);
		start      <= 1'b1;
		plain_high <= ph;
		plain_low  <= pl;
		do @(posedge clk); while (busy);
		board.note_block(ph, pl);
		blocks_sent++;
		// bursty sender: drop start for a random gap once a burst runs out
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end
	endtask

	// Drain: wait until all predictions matched, then past the pipeline depth
	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (14) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random block, sometimes with extreme halves
	task automatic send_random();
		logic [63:0] ph, pl;
		ph = rand64();
		pl = rand64();
		case ($urandom_range(0, 9))
			0: ph = '0;
			1: pl = '1;
			2: begin ph = 64'h1 << $urandom_range(0, 63); pl = '0; end
			default: ;
		endcase
		send_block(ph, pl);
	endtask

	initial begin
		board = new();
		board.key_hi = '0;
		board.key_lo = '0;
		blocks_sent = 0;
		key_writes = 0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		plain_high = '0;
		plain_low = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset key (all zero), extreme plaintexts
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h8000_0000_0000_0000, 64'h1);
		drain();

		// FIPS-197 appendix vector
		write_key(CfgKeyHigh[0:0], 64'h0001_0203_0405_0607);
		write_key(CfgKeyLow[0:0],  64'h0809_0a0b_0c0d_0e0f);
		send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
		send_block('0, '1);
		drain();

		// All-ones key, then one half changed alone
		write_key(CfgKeyHigh[0:0], '1);
		write_key(CfgKeyLow[0:0], '1);
		send_block('0, '0);
		send_block('1, '1);
		drain();
		write_key(CfgKeyLow[0:0], '0);
		send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
		send_block('1, '0);
		drain();

		// Random phases under random keys, back-to-back bursts included
		for (int ph = 0; ph < 12; ph++) begin
			write_key(CfgKeyHigh[0:0], rand64());
			write_key(CfgKeyLow[0:0], rand64());
			repeat (48) send_random();
			drain();
		end

		$display("Encrypted %0d blocks under %0d key writes; %0d ciphertexts checked.",
			blocks_sent, key_writes, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("aes128_block_encrypt_unit_tb: PASS");
		else
			$display("aes128_block_encrypt_unit_tb: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("aes128_block_encrypt_unit_tb: FAIL");
		$finish;
	end

endmodule
